// ===== hdl/lurc_pkg.sv =====
// Package for the least-used replacement cache.
// Holds the opcode type, the wave record that travels along the cell row
// and the write-port record. No dependencies.
package lurc_pkg;

    localparam int TAG_W = 64;
    localparam int PAY_W = 26;
    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    // One request as it sweeps the row, plus what it has found so far.
    typedef struct packed
    {
        logic             valid;
        op_t              op;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] payload;
        logic             done;
        logic [PAY_W-1:0] hit_pay;
        logic [CNT_W-1:0] best_cnt;
    } wave_t;

    // Replacement write broadcast to the row; the slot index travels beside it.
    typedef struct packed
    {
        logic             en;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] payload;
    } evict_wr_t;

endpackage

// ===== hdl/lurc_req_if.sv =====
// Request channel of the least-used replacement cache.
// Valid/ready handshake with the request fields; uses lurc_pkg widths.
interface lurc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [lurc_pkg::TAG_W-1:0]    key_tag;
    logic [lurc_pkg::PAY_W-1:0]    payload;

    modport source (output valid, output opcode, output key_tag, output payload,
                    input ready);
    modport sink (input valid, input opcode, input key_tag, input payload,
                  output ready);
endinterface

// ===== hdl/lurc_rsp_if.sv =====
// Response channel of the least-used replacement cache.
// Valid/ready handshake with the result fields; uses lurc_pkg widths.
interface lurc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [lurc_pkg::PAY_W-1:0]    hit_payload;
    logic                          evicted;

    modport source (output valid, output hit, output hit_payload, output evicted,
                    input ready);
    modport sink (input valid, input hit, input hit_payload, input evicted,
                  output ready);
endinterface

// ===== hdl/lurc_cell.sv =====
// One slot of the cache row: tag, payload, valid bit and use counter.
// Processes the passing request wave and hands it to the next cell.
// Depends on lurc_pkg.
module lurc_cell #(
    parameter int IDX     = 0,
    parameter int IW      = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lurc_pkg::wave_t   wave_in,
    input  logic [IW-1:0]     best_idx_in,
    output lurc_pkg::wave_t   wave_out,
    output logic [IW-1:0]     best_idx_out,
    input  lurc_pkg::evict_wr_t evict_wr,
    input  logic [IW-1:0]     evict_idx
);
    import lurc_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic             valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    wave_t            wave_reg, wave_next;
    logic [IW-1:0]    idx_reg, idx_next;

    // Slot update and wave hand-off.
    always_comb
    begin
        tag_next   = tag_reg;
        pay_next   = pay_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        wave_next  = wave_in;
        idx_next   = best_idx_in;

        if (wave_in.valid)
        begin
            if (wave_in.op == OP_LOOKUP)
            begin
                // The first valid match on the row answers the lookup.
                if (!wave_in.done && valid_reg && (tag_reg == wave_in.tag))
                begin
                    wave_next.done    = 1'b1;
                    wave_next.hit_pay = pay_reg;
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            else
            begin
                // Track the least-used slot in case the row turns out full.
                if ((IDX == 0) || (cnt_reg < wave_in.best_cnt))
                begin
                    wave_next.best_cnt = cnt_reg;
                    idx_next           = MY_IDX;
                end
                // Slots fill in order, so the first empty slot takes the insert.
                if (!wave_in.done && !valid_reg)
                begin
                    tag_next       = wave_in.tag;
                    pay_next       = wave_in.payload;
                    valid_next     = 1'b1;
                    cnt_next       = '0;
                    wave_next.done = 1'b1;
                end
            end
        end

        // Replacement write chosen after the sweep of a full row.
        if (evict_wr.en && (evict_idx == MY_IDX))
        begin
            tag_next   = evict_wr.tag;
            pay_next   = evict_wr.payload;
            valid_next = 1'b1;
            cnt_next   = '0;
        end
    end

    // Slot contents need no reset; they are read only when valid.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        pay_reg <= pay_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            wave_reg  <= wave_next;
        end
    end

    assign wave_out     = wave_reg;
    assign best_idx_out = idx_reg;

endmodule

// ===== hdl/least_used_replacement_cache_core.sv =====
// Top level of the least-used replacement cache: request intake, the cell
// row and the response register. Depends on lurc_pkg, lurc_req_if,
// lurc_rsp_if and lurc_cell.
//
// Usage:
//   req carries opcode (lookup or insert), key_tag and payload; rsp returns
//   hit, hit_payload and evicted, one transfer per request, in order.
//   A request sweeps the row of ENTRIES cells, one cell per cycle. Lookups
//   are answered by the lowest matching valid cell, whose use counter then
//   saturates upward. Inserts fill the first empty cell; on a full row the
//   sweep also finds the lowest-index cell with the smallest count, which
//   is overwritten when the result moves into the response register.
//   The result passes the cell registers, the holding register and the
//   response register before rsp.valid rises. A single wave walks the cell
//   row, so req.ready is low while a request is in the row.
//   Reset clears all valid bits and counters; the cache starts empty.
//   A stalled receiver holds the response register; a finished sweep waits
//   in a holding register, and the next request is taken only once that
//   result has moved into the response register.
module least_used_replacement_cache_core #(
    parameter int ENTRIES = 10
) (
    input  logic clk,
    input  logic rst_n,
    lurc_req_if.sink   req,
    lurc_rsp_if.source rsp
);
    import lurc_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    wave_t         wave     [ENTRIES+1];
    logic [IW-1:0] best_idx [ENTRIES+1];
    evict_wr_t     evict_wr;

    logic          busy_reg, busy_next;
    logic          pend_vld_reg, pend_vld_next;
    wave_t         pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          out_vld_reg, out_vld_next;
    logic          hit_reg, hit_next;
    logic [PAY_W-1:0] hpay_reg, hpay_next;
    logic          evicted_reg, evicted_next;

    logic          accept;
    logic          finish;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    assign finish    = pend_vld_reg && (!out_vld_reg || rsp.ready);

    // Launch a new wave into the first cell on a request transfer.
    always_comb
    begin
        wave[0].valid    = accept;
        wave[0].op       = op_t'(req.opcode);
        wave[0].tag      = req.key_tag;
        wave[0].payload  = req.payload;
        wave[0].done     = 1'b0;
        wave[0].hit_pay  = '0;
        wave[0].best_cnt = CNT_MAX;
        best_idx[0]      = '0;
    end

    // The cell row.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lurc_cell #(
            .IDX     (i),
            .IW      (IW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .wave_in      (wave[i]),
            .best_idx_in  (best_idx[i]),
            .wave_out     (wave[i+1]),
            .best_idx_out (best_idx[i+1]),
            .evict_wr     (evict_wr),
            .evict_idx    (pend_idx_reg)
        );
    end

    // Replacement write for an insert that found no empty slot.
    always_comb
    begin
        evict_wr.en      = finish && (pend_reg.op == OP_INSERT) && !pend_reg.done;
        evict_wr.tag     = pend_reg.tag;
        evict_wr.payload = pend_reg.payload;
    end

    // Holding register, response register and busy flag.
    always_comb
    begin
        busy_next     = busy_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        out_vld_next  = out_vld_reg;
        hit_next      = hit_reg;
        hpay_next     = hpay_reg;
        evicted_next  = evicted_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (wave[ENTRIES].valid)
        begin
            pend_vld_next = 1'b1;
            pend_next     = wave[ENTRIES];
            pend_idx_next = best_idx[ENTRIES];
        end

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        if (finish)
        begin
            pend_vld_next = 1'b0;
            busy_next     = 1'b0;
            out_vld_next  = 1'b1;
            if (pend_reg.op == OP_LOOKUP)
            begin
                hit_next     = pend_reg.done;
                hpay_next    = pend_reg.done ? pend_reg.hit_pay : '0;
                evicted_next = 1'b0;
            end
            else
            begin
                hit_next     = 1'b0;
                hpay_next    = '0;
                evicted_next = !pend_reg.done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        hpay_reg     <= hpay_next;
        evicted_reg  <= evicted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.hit_payload = hpay_reg;
    assign rsp.evicted     = evicted_reg;

endmodule

// ===== verif/tb_least_used_replacement_cache_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for least_used_replacement_cache_core: a queue-fed driver,
// a scoreboard monitor with an in-bench cache predictor, and a stall-prone receiver.
// Depends on lurc_pkg, lurc_req_if, lurc_rsp_if and the core itself.
module tb_least_used_replacement_cache_core;
    import lurc_pkg::*;

    localparam int ENTRIES = 10;
    localparam int RANDOM_ITEMS = 1140;
    localparam int SLOT0_HITS = 30;
    localparam int POOL_SIZE = 12;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 3 * (ENTRIES + 3);

    typedef struct {
        op_t              op;
        logic [TAG_W-1:0] tag;
        logic [PAY_W-1:0] payload;
        int unsigned      gap;
    } cache_req_t;

    typedef struct {
        logic             hit;
        logic [PAY_W-1:0] hit_payload;
        logic             evicted;
    } cache_rsp_t;

    logic clk;
    logic rst_n;

    lurc_req_if req ();
    lurc_rsp_if rsp ();

    least_used_replacement_cache_core #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    // Predictor copy of the cache contents.
    logic [TAG_W-1:0] slot_tag [ENTRIES];
    logic [PAY_W-1:0] slot_pay [ENTRIES];
    logic             slot_valid [ENTRIES];
    logic [CNT_W-1:0] slot_uses [ENTRIES];
    int               slots_filled;

    cache_req_t req_queue [$];
    cache_rsp_t expected_rsps [$];
    cache_req_t next_req;
    logic       holding_req;
    int         gap_left;
    logic       req_taken;
    int         ready_hold;
    int         idle_cycles;
    int         requests_queued;
    int         requests_taken;
    int         rsps_checked;
    int         error_count;
    int         lookup_count;
    int         hit_count;
    int         insert_count;
    int         evict_count;

    // Clock: 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Work out the response to one request and update the predicted cache.
    function automatic cache_rsp_t predict_access(cache_req_t r);
        cache_rsp_t res;
        int victim;
        res.hit = 1'b0;
        res.hit_payload = '0;
        res.evicted = 1'b0;
        if (r.op == OP_LOOKUP)
        begin
            lookup_count++;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (!res.hit && slot_valid[i] && slot_tag[i] == r.tag)
                begin
                    res.hit = 1'b1;
                    res.hit_payload = slot_pay[i];
                    if (slot_uses[i] != CNT_MAX)
                        slot_uses[i] = slot_uses[i] + 1'b1;
                end
            end
            if (res.hit)
                hit_count++;
        end
        else
        begin
            insert_count++;
            if (slots_filled < ENTRIES)
            begin
                victim = slots_filled;
                slots_filled++;
            end
            else
            begin
                // Lowest index wins a tie on the smallest count.
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (slot_uses[i] < slot_uses[victim])
                        victim = i;
                res.evicted = 1'b1;
                evict_count++;
            end
            slot_tag[victim] = r.tag;
            slot_pay[victim] = r.payload;
            slot_valid[victim] = 1'b1;
            slot_uses[victim] = '0;
        end
        return res;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    task automatic queue_req(op_t op, logic [TAG_W-1:0] tag, logic [PAY_W-1:0] pay,
                             int unsigned gap);
        cache_req_t r;
        r.op = op;
        r.tag = tag;
        r.payload = pay;
        r.gap = gap;
        req_queue.insert(req_queue.size(), r);
        requests_queued++;
    endtask

    function automatic logic [TAG_W-1:0] random_tag();
        logic [TAG_W-1:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(0, 15))
            0: t = '0;
            1: t = '1;
            default: ;
        endcase
        return t;
    endfunction

    function automatic logic [PAY_W-1:0] random_payload();
        logic [PAY_W-1:0] p;
        p = PAY_W'($urandom);
        case ($urandom_range(0, 15))
            0: p = '0;
            1: p = '1;
            default: ;
        endcase
        return p;
    endfunction

    // Input defaults from time zero.
    initial
    begin
        req.valid = 1'b0;
        req.opcode = OP_LOOKUP;
        req.key_tag = '0;
        req.payload = '0;
        rsp.ready = 1'b0;
    end

    // Request driver: holds each item until its transfer, inserting the item's gap first.
    always @(negedge clk)
    begin
        if (rst_n && !(req.valid && !req_taken))
        begin
            if (!holding_req && req_queue.size() != 0)
            begin
                next_req = req_queue.pop_front();
                holding_req = 1'b1;
                gap_left = next_req.gap;
            end
            if (holding_req && gap_left == 0)
            begin
                req.valid <= 1'b1;
                req.opcode <= next_req.op;
                req.key_tag <= next_req.tag;
                req.payload <= next_req.payload;
                holding_req = 1'b0;
            end
            else
            begin
                req.valid <= 1'b0;
                if (holding_req)
                    gap_left--;
            end
        end
    end

    // Response receiver: short stalls, short ready runs and long stall-free stretches.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_hold > 0)
                ready_hold--;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        rsp.ready <= 1'b0;
                        ready_hold = $urandom_range(0, 7);
                    end
                    2:
                    begin
                        rsp.ready <= 1'b1;
                        ready_hold = $urandom_range(50, 200);
                    end
                    default:
                    begin
                        rsp.ready <= 1'b1;
                        ready_hold = $urandom_range(0, 10);
                    end
                endcase
            end
        end
    end

    // Monitor: predict on each request transfer, check each response transfer in order.
    always @(posedge clk)
    begin
        cache_rsp_t want;
        if (rst_n)
        begin
            req_taken <= req.valid && req.ready;
            if (req.valid && req.ready)
            begin
                cache_req_t seen;
                seen.op = op_t'(req.opcode);
                seen.tag = req.key_tag;
                seen.payload = req.payload;
                seen.gap = 0;
                expected_rsps.insert(expected_rsps.size(), predict_access(seen));
                requests_taken++;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsps.size() == 0)
                    report_error("response transfer with no request outstanding");
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.hit !== want.hit || rsp.hit_payload !== want.hit_payload ||
                        rsp.evicted !== want.evicted)
                        report_error({$sformatf(
                            "response %0d: expected hit=%0b pay=%h evicted=%0b,",
                            rsps_checked, want.hit, want.hit_payload, want.evicted),
                            $sformatf(" got hit=%0b pay=%h evicted=%0b",
                            rsp.hit, rsp.hit_payload, rsp.evicted)});
                end
                rsps_checked++;
            end
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb_least_used_replacement_cache_core: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and end of run.
    initial
    begin
        logic [TAG_W-1:0] fill_tag [ENTRIES];
        logic [TAG_W-1:0] tag_pool [POOL_SIZE];
        logic [TAG_W-1:0] t;
        int burst_left;
        int unsigned gap;

        holding_req = 1'b0;
        gap_left = 0;
        req_taken = 1'b0;
        ready_hold = 0;
        idle_cycles = 0;
        requests_queued = 0;
        requests_taken = 0;
        rsps_checked = 0;
        error_count = 0;
        lookup_count = 0;
        hit_count = 0;
        insert_count = 0;
        evict_count = 0;
        slots_filled = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_tag[i] = '0;
            slot_pay[i] = '0;
            slot_valid[i] = 1'b0;
            slot_uses[i] = '0;
        end

        // Directed part: a lookup on the empty cache, then fill every slot with distinct
        // tags, the all-zero and all-one tags and payload extremes among them.
        queue_req(OP_LOOKUP, '0, '1, 0);
        for (int i = 0; i < ENTRIES; i++)
        begin
            fill_tag[i] = {32'h8000_0000, 32'(i)} ^ {32'(i * 32'h0101_0101), 32'h0};
            queue_req(OP_INSERT, fill_tag[i], PAY_W'(i * 1000003), $urandom_range(0, 3));
        end
        fill_tag[0] = '0;
        fill_tag[ENTRIES-1] = '1;
        req_queue[1].tag = fill_tag[0];
        req_queue[1].payload = '1;
        req_queue[ENTRIES].tag = fill_tag[ENTRIES-1];
        req_queue[ENTRIES].payload = '0;

        // Give every slot but the first a count of two.
        for (int i = 1; i < ENTRIES; i++)
            repeat (2)
                queue_req(OP_LOOKUP, fill_tag[i], random_payload(), $urandom_range(0, 2));

        // Back-to-back hits give slot 0 a clearly higher count than the rest.
        repeat (SLOT0_HITS)
            queue_req(OP_LOOKUP, fill_tag[0], '0, 0);

        // Full-cache insert: a tie of counts resolves to the lowest index,
        // and the busy entry must survive.
        queue_req(OP_INSERT, 64'h5555_5555_5555_5555, 26'h2AA_AAAA, 1);
        queue_req(OP_LOOKUP, fill_tag[0], '0, 0);
        // Duplicate tag in a lower slot answers ahead of the older copy.
        queue_req(OP_INSERT, fill_tag[ENTRIES-1], 26'h123_4567, 2);
        queue_req(OP_LOOKUP, fill_tag[ENTRIES-1], '0, 0);
        queue_req(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 26'h155_5555, 0);
        queue_req(OP_LOOKUP, fill_tag[ENTRIES-1], '0, 0);
        queue_req(OP_LOOKUP, 64'h0000_0000_0000_0001, '1, 3);

        // Random part: tags mostly from a small shifting pool so lookups hit often.
        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = random_tag();
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 25);
            end
            else
                gap = 0;
            burst_left--;
            if ($urandom_range(0, 19) == 0)
                tag_pool[$urandom_range(0, POOL_SIZE - 1)] = random_tag();
            t = ($urandom_range(0, 6) == 0) ? random_tag()
                                             : tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 9) < 4)
                queue_req(OP_INSERT, t, random_payload(), gap);
            else
                queue_req(OP_LOOKUP, t, random_payload(), gap);
        end

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (requests_taken != requests_queued || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lookups (%0d hits) and %0d inserts (%0d evictions),",
                 lookup_count, hit_count, insert_count, evict_count);
        $display("including a run of %0d hits on one entry; %0d responses checked.",
                 SLOT0_HITS, rsps_checked);
        if (error_count == 0)
            $display("tb_least_used_replacement_cache_core: clean");
        else
        begin
            $display("%0d mismatches in total", error_count);
            $display("tb_least_used_replacement_cache_core: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lurc_pkg.sv
hdl/lurc_req_if.sv
hdl/lurc_rsp_if.sv
hdl/lurc_cell.sv
hdl/least_used_replacement_cache_core.sv
verif/tb_least_used_replacement_cache_core.sv
